### rtl/tcs_pkg.sv
package tcs_pkg;

   // Widths of the value path
   localparam int unsigned DW    = 32;  // Q16.16 coordinate and value width
   localparam int unsigned LW    = 35;  // level value, wide enough for k*spacing + offset
   localparam int unsigned KW    = 33;  // level index
   localparam int unsigned TBITS = 30;  // fractional bits of the edge ratio
   localparam int unsigned TW    = TBITS + 1;
   localparam int unsigned PW    = 64;  // edge product width
   localparam int unsigned SCW   = 6;   // divider step counter

   // Divider step counts
   localparam logic [SCW-1:0] LDIV_STEPS = SCW'(DW);
   localparam logic [SCW-1:0] TDIV_STEPS = SCW'(TBITS);

   // Configuration register indexes
   localparam int unsigned CSR_IW = 8;
   localparam logic [CSR_IW-1:0] CSR_SPACING = 8'd0;
   localparam logic [CSR_IW-1:0] CSR_BASE    = 8'd1;
   localparam logic [CSR_IW-1:0] CSR_MIN     = 8'd2;
   localparam logic [CSR_IW-1:0] CSR_MAX     = 8'd3;

   // Product / result selects
   localparam logic [1:0] SEL_SX = 2'd0;
   localparam logic [1:0] SEL_SY = 2'd1;
   localparam logic [1:0] SEL_EX = 2'd2;
   localparam logic [1:0] SEL_EY = 2'd3;

   typedef struct packed {
      logic signed [DW-1:0] x;
      logic signed [DW-1:0] y;
      logic signed [DW-1:0] v;
   } vertex_type;

   typedef struct packed {
      logic       load;
      logic       sort;
      logic       ldiv_go;
      logic       lset;
      logic       tdiv_go;
      logic       tdiv_short;
      logic       t_long_save;
      logic       t_short_save;
      logic       mul_go;
      logic [1:0] mul_sel;
      logic       res_wr;
      logic [1:0] res_sel;
      logic       adv;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic qual;
      logic div_idle;
      logic at_max;
      logic short_div;
   } status_type;

   typedef enum logic [15:0] {
      S_IDLE = 16'h0001,
      S_SORT = 16'h0002,
      S_CHKE = 16'h0004,
      S_LDIV = 16'h0008,
      S_LSET = 16'h0010,
      S_QUAL = 16'h0020,
      S_TL   = 16'h0040,
      S_WL   = 16'h0080,
      S_TS   = 16'h0100,
      S_WS   = 16'h0200,
      S_M0   = 16'h0400,
      S_M1   = 16'h0800,
      S_M2   = 16'h1000,
      S_M3   = 16'h2000,
      S_M4   = 16'h4000,
      S_EMIT = 16'h8000
   } state_type;

endpackage

### rtl/tcs_div.sv
module tcs_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic [tcs_pkg::DW-1:0]        init_r,
   input  logic [tcs_pkg::DW-1:0]        init_q,
   input  logic [tcs_pkg::DW-1:0]        den,
   input  logic [tcs_pkg::SCW-1:0]       steps,
   output logic                          idle,
   output logic [tcs_pkg::DW-1:0]        quo,
   output logic [tcs_pkg::DW-1:0]        rem
);

   logic                        run_ff, run_in;
   logic [tcs_pkg::SCW-1:0]     cnt_ff, cnt_in;
   logic [tcs_pkg::DW-1:0]      r_ff, r_in;
   logic [tcs_pkg::DW-1:0]      q_ff, q_in;
   logic [tcs_pkg::DW-1:0]      d_ff;
   logic [tcs_pkg::DW:0]        r2;
   logic [tcs_pkg::DW:0]        diff;
   logic                        ge;

   // One restoring step: shift in the next dividend bit, subtract when it fits
   always_comb begin
      r2   = {r_ff, q_ff[tcs_pkg::DW-1]};
      diff = r2 - {1'b0, d_ff};
      ge   = (r2 >= {1'b0, d_ff});
      r_in = ge ? diff[tcs_pkg::DW-1:0] : r2[tcs_pkg::DW-1:0];
      q_in = {q_ff[tcs_pkg::DW-2:0], ge};
   end

   // Step counter
   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      if (go) begin
         run_in = 1'b1;
         cnt_in = steps;
      end else if (run_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == tcs_pkg::SCW'(1)) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
   end

   // Hold remainder and quotient
   always_ff @(posedge clock) begin
      if (go) begin
         r_ff <= init_r;
         q_ff <= init_q;
         d_ff <= den;
      end else if (run_ff) begin
         r_ff <= r_in;
         q_ff <= q_in;
      end
   end

   assign idle = ~run_ff;
   assign quo  = q_ff;
   assign rem  = r_ff;

endmodule

### rtl/tcs_dp.sv
module tcs_dp #(
   parameter int MAX_SEGS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tcs_pkg::cmd_type             cmd,
   output tcs_pkg::status_type          st,
   input  tcs_pkg::vertex_type          vtx_a,
   input  tcs_pkg::vertex_type          vtx_b,
   input  tcs_pkg::vertex_type          vtx_c,
   input  logic [30:0]                  cfg_spacing,
   input  logic signed [31:0]           cfg_base,
   input  logic signed [31:0]           cfg_min,
   input  logic signed [31:0]           cfg_max,
   output logic signed [31:0]           seg_sx,
   output logic signed [31:0]           seg_sy,
   output logic signed [31:0]           seg_ex,
   output logic signed [31:0]           seg_ey,
   output logic signed [31:0]           seg_lnum,
   output logic                         seg_last,
   output logic                         seg_trunc
);

   localparam int CW = $clog2(MAX_SEGS + 1);
   localparam int DW = tcs_pkg::DW;
   localparam int LW = tcs_pkg::LW;
   localparam int KW = tcs_pkg::KW;
   localparam int TW = tcs_pkg::TW;
   localparam int PW = tcs_pkg::PW;

   tcs_pkg::vertex_type va_ff, vb_ff, vc_ff;
   tcs_pkg::vertex_type p1_ff, p2_ff, p3_ff;
   tcs_pkg::vertex_type s1, s2, s3, tv;

   logic [30:0]              sp;
   logic [13:0]              off;
   logic signed [DW-1:0]     lo, lo_ff;
   logic                     neg_ff;
   logic signed [KW-1:0]     k_ff, k_in;
   logic signed [LW-1:0]     lvl_ff, lvl_in;
   logic [CW-1:0]            cnt_ff;
   logic [TW-1:0]            tl_ff, ts_ff;
   logic                     tint_ff;
   logic signed [PW-1:0]     prod_ff;
   logic signed [DW-1:0]     sx_ff, sy_ff, ex_ff, ey_ff, lnum_ff;

   logic signed [LW-1:0]     v1_x, v2_x, v3_x, max_x, lo_x, r_x, sp_x, off_x, kmul;
   logic signed [LW-1:0]     numl_x, denl_x, nums_x, dens_x;
   logic [DW-1:0]            t_num, t_den, t_r0;
   logic [DW:0]              t_sub;
   logic                     t_ge;
   logic                     hi, deg, rnz;
   logic [DW-1:0]            lo_abs;

   logic                     div_go, div_idle;
   logic [DW-1:0]            div_r, div_q, div_d, div_quo, div_rem;
   logic [tcs_pkg::SCW-1:0]  div_steps;

   logic signed [DW:0]       mul_a;
   logic signed [DW-1:0]     mul_b;
   logic signed [PW:0]       mul_full;
   logic signed [DW-1:0]     res_base;
   logic signed [PW-1:0]     rnd;
   logic signed [PW-1:0]     shr;
   logic signed [DW-1:0]     res;
   logic signed [KW:0]       lnum_w;

   // Spacing of zero counts as one
   assign sp  = (cfg_spacing == 31'd0) ? 31'd1 : cfg_spacing;
   assign off = sp[30:17];

   // Sorting network on the value, strict compare keeps equal values in order
   always_comb begin
      s1 = va_ff;
      s2 = vb_ff;
      s3 = vc_ff;
      tv = va_ff;
      if (s1.v > s2.v) begin
         tv = s1; s1 = s2; s2 = tv;
      end
      if (s2.v > s3.v) begin
         tv = s2; s2 = s3; s3 = tv;
      end
      if (s1.v > s2.v) begin
         tv = s1; s1 = s2; s2 = tv;
      end
   end

   // Extended copies of the sorted values
   always_comb begin
      v1_x  = LW'(p1_ff.v);
      v2_x  = LW'(p2_ff.v);
      v3_x  = LW'(p3_ff.v);
      max_x = LW'(cfg_max);
      lo_x  = LW'(lo_ff);
      r_x   = $signed({3'b000, div_rem});
      sp_x  = $signed({4'b0000, sp});
      off_x = $signed({21'd0, off});
   end

   // Floor the first level at the global minimum
   assign lo     = (p1_ff.v > cfg_min) ? p1_ff.v : cfg_min;
   assign lo_abs = lo[DW-1] ? DW'(-lo) : DW'(lo);

   // First level index and value from quotient and remainder
   always_comb begin
      rnz = (div_rem != '0);
      if (neg_ff) begin
         k_in = -$signed({1'b0, div_quo});
         kmul = lo_x + r_x;
      end else begin
         k_in = $signed({1'b0, div_quo}) + $signed(KW'(rnz));
         kmul = lo_x - r_x + (rnz ? sp_x : '0);
      end
      lvl_in = kmul + off_x;
   end

   // Edge ratios: long edge v1-v3, short edge v2-v3 above v2, v2-v1 below
   always_comb begin
      hi     = (lvl_ff > v2_x);
      deg    = ~hi & (p2_ff.v == p1_ff.v);
      numl_x = lvl_ff - v1_x;
      denl_x = v3_x - v1_x;
      nums_x = hi ? (lvl_ff - v2_x) : (v2_x - lvl_ff);
      dens_x = hi ? (v3_x - v2_x) : (v2_x - v1_x);
      t_num  = cmd.tdiv_short ? nums_x[DW-1:0] : numl_x[DW-1:0];
      t_den  = cmd.tdiv_short ? dens_x[DW-1:0] : denl_x[DW-1:0];
      t_sub  = {1'b0, t_num} - {1'b0, t_den};
      t_ge   = (t_num >= t_den);
      t_r0   = t_ge ? t_sub[DW-1:0] : t_num;
   end

   // Divider operands
   always_comb begin
      div_go = cmd.ldiv_go | cmd.tdiv_go;
      if (cmd.ldiv_go) begin
         div_r     = '0;
         div_q     = lo_abs;
         div_d     = {1'b0, sp};
         div_steps = tcs_pkg::LDIV_STEPS;
      end else begin
         div_r     = t_r0;
         div_q     = '0;
         div_d     = t_den;
         div_steps = tcs_pkg::TDIV_STEPS;
      end
   end

   tcs_div u_div (
      .clock  (clock),
      .reset  (reset),
      .go     (div_go),
      .init_r (div_r),
      .init_q (div_q),
      .den    (div_d),
      .steps  (div_steps),
      .idle   (div_idle),
      .quo    (div_quo),
      .rem    (div_rem)
   );

   // Multiplier operands
   always_comb begin
      case (cmd.mul_sel)
         tcs_pkg::SEL_SX: begin
            mul_a = (DW+1)'(p3_ff.x) - (DW+1)'(p1_ff.x);
            mul_b = $signed({1'b0, tl_ff});
         end
         tcs_pkg::SEL_SY: begin
            mul_a = (DW+1)'(p3_ff.y) - (DW+1)'(p1_ff.y);
            mul_b = $signed({1'b0, tl_ff});
         end
         tcs_pkg::SEL_EX: begin
            mul_a = (hi ? (DW+1)'(p3_ff.x) : (DW+1)'(p1_ff.x)) - (DW+1)'(p2_ff.x);
            mul_b = $signed({1'b0, ts_ff});
         end
         tcs_pkg::SEL_EY: begin
            mul_a = (hi ? (DW+1)'(p3_ff.y) : (DW+1)'(p1_ff.y)) - (DW+1)'(p2_ff.y);
            mul_b = $signed({1'b0, ts_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_full = mul_a * mul_b;
   end

   // Round the product to nearest, halves upward, and add the edge origin
   always_comb begin
      case (cmd.res_sel)
         tcs_pkg::SEL_SX: res_base = p1_ff.x;
         tcs_pkg::SEL_SY: res_base = p1_ff.y;
         tcs_pkg::SEL_EX: res_base = p2_ff.x;
         tcs_pkg::SEL_EY: res_base = p2_ff.y;
         default:         res_base = '0;
      endcase
      rnd = prod_ff + (PW'(1) <<< (tcs_pkg::TBITS - 1));
      shr = rnd >>> tcs_pkg::TBITS;
      res = res_base + shr[DW-1:0];
   end

   assign lnum_w = (KW+1)'(k_ff) - (KW+1)'(cfg_base);

   // Control-side registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.lset) begin
         cnt_ff <= '0;
      end else if (cmd.adv) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         va_ff <= vtx_a;
         vb_ff <= vtx_b;
         vc_ff <= vtx_c;
      end
      if (cmd.sort) begin
         p1_ff <= s1;
         p2_ff <= s2;
         p3_ff <= s3;
      end
      if (cmd.ldiv_go) begin
         lo_ff  <= lo;
         neg_ff <= lo[DW-1];
      end
      if (cmd.lset) begin
         k_ff   <= k_in;
         lvl_ff <= lvl_in;
      end else if (cmd.adv) begin
         k_ff    <= k_ff + KW'(1);
         lvl_ff  <= lvl_ff + sp_x;
         lnum_ff <= lnum_w[DW-1:0];
      end
      if (cmd.tdiv_go) begin
         tint_ff <= t_ge;
      end
      if (cmd.t_long_save) begin
         tl_ff <= {tint_ff, div_quo[tcs_pkg::TBITS-1:0]};
      end
      if (cmd.t_short_save) begin
         ts_ff <= {tint_ff, div_quo[tcs_pkg::TBITS-1:0]};
      end
      if (cmd.mul_go) begin
         prod_ff <= mul_full[PW-1:0];
      end
      if (cmd.res_wr) begin
         case (cmd.res_sel)
            tcs_pkg::SEL_SX: sx_ff <= res;
            tcs_pkg::SEL_SY: sy_ff <= res;
            tcs_pkg::SEL_EX: ex_ff <= deg ? p2_ff.x : res;
            tcs_pkg::SEL_EY: ey_ff <= deg ? p2_ff.y : res;
            default: ;
         endcase
      end
   end

   // Status towards the controller
   always_comb begin
      st.empty     = (p1_ff.v == p3_ff.v);
      st.qual      = ~(lvl_ff > v3_x) & ~(lvl_ff > max_x);
      st.div_idle  = div_idle;
      st.at_max    = (cnt_ff == CW'(MAX_SEGS));
      st.short_div = ~deg;
   end

   assign seg_sx    = sx_ff;
   assign seg_sy    = sy_ff;
   assign seg_ex    = ex_ff;
   assign seg_ey    = ey_ff;
   assign seg_lnum  = lnum_ff;
   assign seg_last  = ~st.qual | st.at_max;
   assign seg_trunc = st.qual & st.at_max;

endmodule

### rtl/tcs_ctrl.sv
module tcs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  tcs_pkg::status_type  st,
   output tcs_pkg::cmd_type     cmd
);

   tcs_pkg::state_type state_ff, state_in;

   // Sequence one triangle: sort, level division, then per level one or two ratios and four products
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         tcs_pkg::S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = tcs_pkg::S_SORT;
            end
         end
         tcs_pkg::S_SORT: begin
            cmd.sort = 1'b1;
            state_in = tcs_pkg::S_CHKE;
         end
         tcs_pkg::S_CHKE: begin
            if (st.empty) begin
               state_in = tcs_pkg::S_IDLE;
            end else begin
               cmd.ldiv_go = 1'b1;
               state_in    = tcs_pkg::S_LDIV;
            end
         end
         tcs_pkg::S_LDIV: begin
            if (st.div_idle) begin
               state_in = tcs_pkg::S_LSET;
            end
         end
         tcs_pkg::S_LSET: begin
            cmd.lset = 1'b1;
            state_in = tcs_pkg::S_QUAL;
         end
         tcs_pkg::S_QUAL: begin
            state_in = st.qual ? tcs_pkg::S_TL : tcs_pkg::S_IDLE;
         end
         tcs_pkg::S_TL: begin
            cmd.tdiv_go = 1'b1;
            state_in    = tcs_pkg::S_WL;
         end
         tcs_pkg::S_WL: begin
            if (st.div_idle) begin
               cmd.t_long_save = 1'b1;
               state_in = st.short_div ? tcs_pkg::S_TS : tcs_pkg::S_M0;
            end
         end
         tcs_pkg::S_TS: begin
            cmd.tdiv_go    = 1'b1;
            cmd.tdiv_short = 1'b1;
            state_in       = tcs_pkg::S_WS;
         end
         tcs_pkg::S_WS: begin
            if (st.div_idle) begin
               cmd.t_short_save = 1'b1;
               state_in = tcs_pkg::S_M0;
            end
         end
         tcs_pkg::S_M0: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = tcs_pkg::SEL_SX;
            state_in    = tcs_pkg::S_M1;
         end
         tcs_pkg::S_M1: begin
            cmd.res_wr  = 1'b1;
            cmd.res_sel = tcs_pkg::SEL_SX;
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = tcs_pkg::SEL_SY;
            state_in    = tcs_pkg::S_M2;
         end
         tcs_pkg::S_M2: begin
            cmd.res_wr  = 1'b1;
            cmd.res_sel = tcs_pkg::SEL_SY;
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = tcs_pkg::SEL_EX;
            state_in    = tcs_pkg::S_M3;
         end
         tcs_pkg::S_M3: begin
            cmd.res_wr  = 1'b1;
            cmd.res_sel = tcs_pkg::SEL_EX;
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = tcs_pkg::SEL_EY;
            state_in    = tcs_pkg::S_M4;
         end
         tcs_pkg::S_M4: begin
            cmd.res_wr  = 1'b1;
            cmd.res_sel = tcs_pkg::SEL_EY;
            cmd.mul_sel = tcs_pkg::SEL_EY;
            cmd.adv     = 1'b1;
            state_in    = tcs_pkg::S_EMIT;
         end
         tcs_pkg::S_EMIT: begin
            // Present the segment; the next level has already been checked
            cmd.emit = 1'b1;
            if (~st.qual | st.at_max) begin
               state_in = tcs_pkg::S_IDLE;
            end else begin
               state_in = tcs_pkg::S_TL;
            end
         end
         default: begin
            state_in = tcs_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcs_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != tcs_pkg::S_IDLE);

endmodule

### rtl/triangle_contour_segments.sv
// Channel  Handshake               Payload
// req      start / busy            req_ax .. req_cv (three vertices, x y value)
// rsp      rsp_valid strobe        start/end point, level number, last, truncated
// csr      csr_valid / csr_ready   csr_index, csr_data
//
// A triangle is sorted and set up, and the level division finds the first
// level. Per segment follow the long-edge ratio division, the short-edge ratio
// division (skipped when the end point is the vertex) and four products. One
// restoring divider is shared by all divisions. Synchronous reset returns the
// controller, divider and configuration registers to their defaults. Results
// are strobed for one cycle and cannot be held off.
module triangle_contour_segments #(
   parameter int MAX_SEGS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic signed [31:0]  req_ax,
   input  logic signed [31:0]  req_ay,
   input  logic signed [31:0]  req_av,
   input  logic signed [31:0]  req_bx,
   input  logic signed [31:0]  req_by,
   input  logic signed [31:0]  req_bv,
   input  logic signed [31:0]  req_cx,
   input  logic signed [31:0]  req_cy,
   input  logic signed [31:0]  req_cv,
   output logic                rsp_valid,
   output logic signed [31:0]  rsp_start_x,
   output logic signed [31:0]  rsp_start_y,
   output logic signed [31:0]  rsp_end_x,
   output logic signed [31:0]  rsp_end_y,
   output logic signed [31:0]  rsp_level_number,
   output logic                rsp_last_segment,
   output logic                rsp_truncated,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [7:0]          csr_index,
   input  logic [31:0]         csr_data
);

   tcs_pkg::cmd_type     cmd;
   tcs_pkg::status_type  st;
   tcs_pkg::vertex_type  vtx_a, vtx_b, vtx_c;

   logic [30:0]         spacing_ff;
   logic signed [31:0]  base_ff, min_ff, max_ff;

   // Write configuration registers on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff <= 31'd65536;
         base_ff    <= '0;
         min_ff     <= '0;
         max_ff     <= '0;
      end else if (csr_valid & csr_ready) begin
         case (csr_index)
            tcs_pkg::CSR_SPACING: spacing_ff <= csr_data[30:0];
            tcs_pkg::CSR_BASE:    base_ff    <= csr_data;
            tcs_pkg::CSR_MIN:     min_ff     <= csr_data;
            tcs_pkg::CSR_MAX:     max_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   assign vtx_a = '{x: req_ax, y: req_ay, v: req_av};
   assign vtx_b = '{x: req_bx, y: req_by, v: req_bv};
   assign vtx_c = '{x: req_cx, y: req_cy, v: req_cv};

   tcs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .st    (st),
      .cmd   (cmd)
   );

   tcs_dp #(
      .MAX_SEGS (MAX_SEGS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .st          (st),
      .vtx_a       (vtx_a),
      .vtx_b       (vtx_b),
      .vtx_c       (vtx_c),
      .cfg_spacing (spacing_ff),
      .cfg_base    (base_ff),
      .cfg_min     (min_ff),
      .cfg_max     (max_ff),
      .seg_sx      (rsp_start_x),
      .seg_sy      (rsp_start_y),
      .seg_ex      (rsp_end_x),
      .seg_ey      (rsp_end_y),
      .seg_lnum    (rsp_level_number),
      .seg_last    (rsp_last_segment),
      .seg_trunc   (rsp_truncated)
   );

   assign rsp_valid = cmd.emit;

endmodule

### verif/triangle_contour_segments_test.sv
module triangle_contour_segments_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SEG_LIMIT  = 64;
   localparam int IDLE_LIMIT = 4000;
   localparam int SETTLE     = 120;

   typedef struct {
      logic signed [31:0] sx, sy, ex, ey, lvl;
      logic               last, trunc;
   } segment_type;

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic signed [31:0] req_ax = 0, req_ay = 0, req_av = 0;
   logic signed [31:0] req_bx = 0, req_by = 0, req_bv = 0;
   logic signed [31:0] req_cx = 0, req_cy = 0, req_cv = 0;
   logic               rsp_valid;
   logic signed [31:0] rsp_start_x, rsp_start_y, rsp_end_x, rsp_end_y, rsp_level_number;
   logic               rsp_last_segment, rsp_truncated;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic [7:0]         csr_index = 0;
   logic [31:0]        csr_data = 0;

   // shadow copy of the register file
   longint       spacing_q, base_q, min_q, max_q;
   segment_type  pending_segments[$];
   int           mismatches = 0;
   int           idle_cycles = 0;
   int           burst_left = 0;
   bit           gaps_on = 1;

   triangle_contour_segments #(.MAX_SEGS(SEG_LIMIT)) uut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // point at fraction num/den along an edge, ratio floored then product rounded
   function automatic longint edge_point(longint a, longint b, longint num, longint den);
      longint unsigned t;
      longint          q;
      t = (longint'(num) << tcs_pkg::TBITS) / longint'(den);
      q = (b - a) * longint'(t) + (longint'(1) << (tcs_pkg::TBITS - 1));
      return a + (q >>> tcs_pkg::TBITS);
   endfunction

   // work out every segment one triangle gives and queue them
   function automatic void predict_segments(logic signed [31:0] x[3], logic signed [31:0] y[3],
                                            logic signed [31:0] v[3]);
      int          a = 0, b = 1, c = 2, s, cnt = 0;
      longint      sp, off, lo, k, lvl, ex, ey;
      segment_type seg;
      bit          cut = 0;
      bit          done = 0;
      if (v[a] > v[b]) begin s = a; a = b; b = s; end
      if (v[b] > v[c]) begin s = b; b = c; c = s; end
      if (v[a] > v[b]) begin s = a; a = b; b = s; end
      if (v[a] == v[c]) return;
      sp  = (spacing_q == 0) ? 1 : spacing_q;
      off = sp >> 17;
      lo  = (longint'(v[a]) > min_q) ? longint'(v[a]) : min_q;
      k   = lo / sp;
      if (lo % sp != 0 && lo > 0) k++;
      while (!done) begin
         lvl = k * sp + off;
         if (lvl > v[c] || lvl > max_q) begin
            done = 1;
         end else if (cnt == SEG_LIMIT) begin
            cut  = 1;
            done = 1;
         end else begin
            seg.sx = 32'(edge_point(x[a], x[c], lvl - v[a], longint'(v[c]) - v[a]));
            seg.sy = 32'(edge_point(y[a], y[c], lvl - v[a], longint'(v[c]) - v[a]));
            if (lvl > v[b]) begin
               ex = edge_point(x[b], x[c], lvl - v[b], longint'(v[c]) - v[b]);
               ey = edge_point(y[b], y[c], lvl - v[b], longint'(v[c]) - v[b]);
            end else if (v[b] == v[a]) begin
               ex = x[b];
               ey = y[b];
            end else begin
               ex = edge_point(x[b], x[a], longint'(v[b]) - lvl, longint'(v[b]) - v[a]);
               ey = edge_point(y[b], y[a], longint'(v[b]) - lvl, longint'(v[b]) - v[a]);
            end
            seg.ex    = ex[31:0];
            seg.ey    = ey[31:0];
            seg.lvl   = 32'(k - base_q);
            seg.last  = 0;
            seg.trunc = 0;
            pending_segments.insert(pending_segments.size(), seg);
            cnt++;
            k++;
         end
      end
      if (cnt > 0) begin
         pending_segments[$].last  = 1;
         pending_segments[$].trunc = cut;
      end
   endfunction

   // compare each strobed segment and watch for a stall
   always @(posedge clock) begin
      segment_type want;
      if (!reset) begin
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
         if (rsp_valid) begin
            if (pending_segments.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected segment, level %0d", rsp_level_number);
            end else begin
               want = pending_segments.pop_front();
               if (rsp_start_x !== want.sx || rsp_start_y !== want.sy ||
                   rsp_end_x !== want.ex || rsp_end_y !== want.ey ||
                   rsp_level_number !== want.lvl || rsp_last_segment !== want.last ||
                   rsp_truncated !== want.trunc) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"segment mismatch: exp %0d %0d %0d %0d lvl %0d l%0b t%0b,",
                               " got %0d %0d %0d %0d lvl %0d l%0b t%0b"},
                              want.sx, want.sy, want.ex, want.ey, want.lvl, want.last,
                              want.trunc, rsp_start_x, rsp_start_y, rsp_end_x, rsp_end_y,
                              rsp_level_number, rsp_last_segment, rsp_truncated);
               end
            end
         end
      end
   end

   // one triangle transfer, with bursts and gaps in front
   task automatic send_triangle(logic signed [31:0] x[3], logic signed [31:0] y[3],
                                logic signed [31:0] v[3]);
      if (gaps_on && burst_left == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      start  <= 1;
      req_ax <= x[0]; req_ay <= y[0]; req_av <= v[0];
      req_bx <= x[1]; req_by <= y[1]; req_bv <= v[1];
      req_cx <= x[2]; req_cy <= y[2]; req_cv <= v[2];
      do @(posedge clock); while (busy);
      predict_segments(x, y, v);
   endtask

   // hold until every segment is in and the block has settled
   task automatic drain;
      start <= 0;
      while (pending_segments.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [7:0] idx, logic [31:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (idx)
         tcs_pkg::CSR_SPACING: spacing_q = value[30:0];
         tcs_pkg::CSR_BASE:    base_q    = longint'(signed'(value));
         tcs_pkg::CSR_MIN:     min_q     = longint'(signed'(value));
         tcs_pkg::CSR_MAX:     max_q     = longint'(signed'(value));
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_levels(logic [31:0] sp, logic [31:0] bi, logic [31:0] lo, logic [31:0] hi);
      drain();
      write_reg(tcs_pkg::CSR_SPACING, sp);
      write_reg(tcs_pkg::CSR_BASE, bi);
      write_reg(tcs_pkg::CSR_MIN, lo);
      write_reg(tcs_pkg::CSR_MAX, hi);
   endtask

   task automatic send_values(int va, int vb, int vc);
      logic signed [31:0] x[3], y[3], v[3];
      for (int i = 0; i < 3; i++) begin
         x[i] = $urandom;
         y[i] = $urandom;
      end
      v[0] = va; v[1] = vb; v[2] = vc;
      send_triangle(x, y, v);
   endtask

   // reset values, equal values, flat bottom, vertex ends, order variants
   task automatic test_directed;
      logic signed [31:0] x[3], y[3], v[3];
      gaps_on = 0;
      max_q = 0;
      send_values(-65536, 0, 65536);
      set_levels(32'd65536, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF);
      send_values(100000, 100000, 100000);
      send_values(0, 0, 3 * 65536);
      send_values(3 * 65536, 0, 0);
      send_values(2 * 65536, 65536, 0);
      send_values(65536, 65536 * 5, 65536 * 2);
      send_values(-5 * 65536, 5 * 65536, 0);
      x = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0};
      y = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
      v = '{0, 65536, 2 * 65536};
      send_triangle(x, y, v);
      v = '{32'h8000_0000, 32'h7FFF_FFFF, 0};
      send_triangle(x, y, v);
      // more levels than the segment limit allows
      send_values(0, 100 * 65536, 50 * 65536);
      send_values(0, 64 * 65536 + 5, 3);
      set_levels(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      send_values(32'h8000_0000, 0, 32'h7FFF_FFFF);
      send_values(32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFE);
      set_levels(32'd0, 32'h7FFF_FFFF, -32'sd20, 32'd10);
      send_values(-40, 5, 40);
      send_values(-3, -3, 3);
      set_levels(32'd1000, 32'd3, 32'd500, 32'd1500);
      write_reg(8'hFF, 32'hFFFF_FFFF);
      send_values(0, 1000, 3000);
      send_values(-2000, 1200, 1200);
      gaps_on = 1;
   endtask

   // random windows of values around the contour range of each setting
   task automatic test_random(int n_items, logic [31:0] sp);
      logic signed [31:0] x[3], y[3], v[3];
      longint centre, span, w;
      int     pick;
      set_levels(sp, $urandom, 32'h8000_0000, 32'h7FFF_FFFF);
      centre = longint'(signed'($urandom)) >>> $urandom_range(0, 8);
      if ($urandom_range(0, 2) == 0) write_reg(tcs_pkg::CSR_MIN, 32'(centre - sp));
      if ($urandom_range(0, 2) == 0) write_reg(tcs_pkg::CSR_MAX, 32'(centre + 4 * longint'(sp)));
      gaps_on = $urandom_range(0, 3) != 0;
      for (int n = 0; n < n_items; n++) begin
         pick = $urandom_range(0, 19);
         span = (pick == 0) ? 80 * longint'(sp) : longint'(sp) * $urandom_range(0, 8) + 1;
         for (int i = 0; i < 3; i++) begin
            x[i] = $urandom;
            y[i] = $urandom;
            w = centre + $urandom_range(0, 32'(span > 32'h7FFF_FFFF ? 32'h7FFF_FFFF : span));
            if (w > 64'sh7FFF_FFFF) w = 64'sh7FFF_FFFF;
            v[i] = (pick == 1) ? 32'($urandom) : 32'(w);
         end
         if (pick == 2) v[1] = v[0];
         if (pick == 3) v[2] = v[1];
         if (pick == 4) begin v[1] = v[0]; v[2] = v[0]; end
         send_triangle(x, y, v);
      end
   endtask

   initial begin
      spacing_q = 65536;
      base_q    = 0;
      min_q     = 0;
      max_q     = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_random(100, 32'd65536);
      test_random(100, $urandom_range(1, 4096));
      test_random(100, 32'h7FFF_FFFF);
      test_random(100, $urandom_range(1 << 16, 1 << 24));
      test_random(100, $urandom_range(1 << 24, 32'h7FFF_FFFF));
      drain();
      if (mismatches == 0 && pending_segments.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### triangle_contour_segments.f
rtl/tcs_pkg.sv
rtl/tcs_div.sv
rtl/tcs_dp.sv
rtl/tcs_ctrl.sv
rtl/triangle_contour_segments.sv
verif/triangle_contour_segments_test.sv
